// ===== hw/rtl/rgb565_color_slew_tracker_defines.svh =====
// Assertion macros for the RGB565 color slew tracker.
// Used by the top level; expects clk and rst_n in scope at the point of use.
`ifndef RGB565_COLOR_SLEW_TRACKER_DEFINES_SVH
`define RGB565_COLOR_SLEW_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define CST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define CST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CST_ASSERT_SAME(label, ante, cons, msg)
`define CST_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/cst_pkg.sv =====
// Shared types, operation codes and RGB565 helpers for the color slew tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cst_pkg;

    localparam logic [6:0] WHEEL_MAX = 7'd95;

    typedef enum logic [2:0] {
        OP_LOAD_CURRENT = 3'd0,
        OP_LOAD_TARGET  = 3'd1,
        OP_WHEEL        = 3'd2,
        OP_WHEEL_BRIGHT = 3'd3,
        OP_STEP         = 3'd4
    } cst_op_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] color_value;
        logic [6:0]  wheel_position;
    } cst_req_t;

    typedef struct packed {
        logic [15:0] current_color;
        logic [15:0] half_color;
        logic [15:0] quarter_color;
        logic [6:0]  last_wheel;
    } cst_rsp_t;

    // Shift each channel right by one and repack.
    function automatic logic [15:0] dim_half(input logic [15:0] c);
        dim_half = {1'b0, c[15:12], 1'b0, c[10:6], 1'b0, c[4:1]};
    endfunction

    // Shift each channel right by two and repack.
    function automatic logic [15:0] dim_quarter(input logic [15:0] c);
        dim_quarter = {2'b00, c[15:13], 2'b00, c[10:7], 2'b00, c[4:2]};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cst_wheel.sv =====
// Color-wheel position to RGB565 target color, with clamp of the position.
// Depends on cst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cst_wheel (
    input  wire logic [6:0]  position,
    input  wire logic        bright,
    output logic      [6:0]  clamped,
    output logic      [15:0] color
);
    import cst_pkg::*;

    logic [4:0] r;
    logic [4:0] g;
    logic [4:0] b;
    logic [4:0] lo;
    logic [4:0] full;

    always_comb
    begin
        clamped = (position > WHEEL_MAX) ? WHEEL_MAX : position;
        lo      = clamped[4:0];
        full    = bright ? 5'd31 : 5'd0;
        // Within each 32-wide segment, 31 - offset is the inverted offset.
        if (clamped < 7'd32)
        begin
            r = full;
            g = lo;
            b = ~lo;
        end
        else if (clamped < 7'd64)
        begin
            r = lo;
            g = ~lo;
            b = full;
        end
        else
        begin
            r = ~lo;
            g = full;
            b = lo;
        end
        color = {r, g, 1'b0, b};
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cst_step.sv =====
// One slew step of an RGB565 color toward a target color.
// Depends on cst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cst_step (
    input  wire logic [15:0] current,
    input  wire logic [15:0] target,
    output logic      [15:0] stepped
);
    import cst_pkg::*;

    logic [4:0] r;
    logic [4:0] b;
    logic [5:0] g;
    logic [4:0] tr;
    logic [4:0] tb;
    logic [6:0] g_wide;
    logic [6:0] tg_wide;

    always_comb
    begin
        tr      = target[15:11];
        tb      = target[4:0];
        g_wide  = {1'b0, current[10:5]};
        tg_wide = {1'b0, target[10:5]};

        r = current[15:11];
        if (r > tr)
            r = r - 5'd1;
        else if (r < tr)
            r = r + 5'd1;

        b = current[4:0];
        if (b > tb)
            b = b - 5'd1;
        else if (b < tb)
            b = b + 5'd1;

        // Green moves two counts, and holds when within one of the target.
        g = current[10:5];
        if (g_wide > tg_wide + 7'd1)
            g = g - 6'd2;
        else if (g_wide + 7'd1 < tg_wide)
            g = g + 6'd2;

        stepped = {r, g, b};
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rgb565_color_slew_tracker.sv =====
// Top level of the RGB565 color slew tracker: request register, state, result register.
// Depends on cst_pkg, cst_wheel, cst_step and rgb565_color_slew_tracker_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

// The tracker holds a current RGB565 color, a target color and the last
// color-wheel position. Each request loads the current color, loads the
// target, sets the target from a wheel position (clamped to 95; plain or
// bright variant, wheel green doubled into the 6-bit field), or steps the
// current color toward the target (red and blue by one count, green by two
// when more than one count away). Codes 5 to 7 change nothing. Every request
// returns exactly one result: the current color after the request, its half
// and quarter brightness versions, and the latched wheel position.
// Rate: one request per cycle sustained while result_ready is high. A request
// is captured in the request register, evaluated there by the wheel and step
// logic and written to the result register together with the state update
// once the result register is free or draining. The result register lets a
// new request enter while an earlier result waits; the pipe holds up to two
// requests when the result side stalls.
module rgb565_color_slew_tracker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            request_valid,
    output logic                 request_ready,
    input  wire cst_pkg::cst_req_t request,
    output logic                 result_valid,
    input  wire logic            result_ready,
    output cst_pkg::cst_rsp_t    result
);
    import cst_pkg::*;

    `include "rgb565_color_slew_tracker_defines.svh"

    // Request stage
    logic     req_valid_reg;
    logic     req_valid_next;
    cst_req_t req_item_reg;

    // Block state
    logic [15:0] current_rgb_reg;
    logic [15:0] current_rgb_next;
    logic [15:0] target_rgb_reg;
    logic [15:0] target_rgb_next;
    logic [6:0]  wheel_latch_reg;
    logic [6:0]  wheel_latch_next;

    // Result stage
    logic     rsp_valid_reg;
    logic     rsp_valid_next;
    cst_rsp_t rsp_item_reg;
    cst_rsp_t rsp_item_next;

    logic        advance;
    logic [6:0]  wheel_clamped;
    logic [15:0] wheel_color;
    logic [15:0] step_color;

    cst_wheel u_wheel (
        .position (req_item_reg.wheel_position),
        .bright   (req_item_reg.operation == OP_WHEEL_BRIGHT),
        .clamped  (wheel_clamped),
        .color    (wheel_color)
    );

    cst_step u_step (
        .current (current_rgb_reg),
        .target  (target_rgb_reg),
        .stepped (step_color)
    );

    // Advance the held request when the result register is free or draining.
    assign advance       = req_valid_reg && (!rsp_valid_reg || result_ready);
    assign request_ready = !req_valid_reg || advance;
    assign result_valid  = rsp_valid_reg;
    assign result        = rsp_item_reg;

    always_comb
    begin
        current_rgb_next = current_rgb_reg;
        target_rgb_next  = target_rgb_reg;
        wheel_latch_next = wheel_latch_reg;

        case (cst_op_t'(req_item_reg.operation))
            OP_LOAD_CURRENT: current_rgb_next = req_item_reg.color_value;
            OP_LOAD_TARGET:  target_rgb_next  = req_item_reg.color_value;
            OP_WHEEL,
            OP_WHEEL_BRIGHT:
            begin
                target_rgb_next  = wheel_color;
                wheel_latch_next = wheel_clamped;
            end
            OP_STEP:         current_rgb_next = step_color;
            default:         ;  // unused codes: hold state
        endcase

        rsp_item_next.current_color = current_rgb_next;
        rsp_item_next.half_color    = dim_half(current_rgb_next);
        rsp_item_next.quarter_color = dim_quarter(current_rgb_next);
        rsp_item_next.last_wheel    = wheel_latch_next;

        // Hold the request stage full if a new request replaces the one leaving.
        req_valid_next = request_valid && request_ready ? 1'b1 :
                         (advance ? 1'b0 : req_valid_reg);
        // Drop the result once taken, unless a new one arrives.
        rsp_valid_next = advance ? 1'b1 :
                         (result_ready ? 1'b0 : rsp_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg   <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            current_rgb_reg <= 16'd0;
            target_rgb_reg  <= 16'd0;
            wheel_latch_reg <= 7'd0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (advance)
            begin
                current_rgb_reg <= current_rgb_next;
                target_rgb_reg  <= target_rgb_next;
                wheel_latch_reg <= wheel_latch_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (request_valid && request_ready)
            req_item_reg <= request;
        if (advance)
            rsp_item_reg <= rsp_item_next;
    end

    // Checks
    `CST_ASSERT_NEXT(a_blocked_request_held, req_valid_reg && !advance, req_valid_reg, "blocked request lost from request stage")
    `CST_ASSERT_NEXT(a_load_current, advance && (req_item_reg.operation == OP_LOAD_CURRENT), current_rgb_reg == $past(req_item_reg.color_value), "load current did not update state")
    `CST_ASSERT_SAME(a_wheel_in_range, rsp_valid_reg, rsp_item_reg.last_wheel <= WHEEL_MAX, "latched wheel position above range")
    `CST_ASSERT_SAME(a_quarter_matches, rsp_valid_reg, rsp_item_reg.quarter_color == dim_quarter(rsp_item_reg.current_color), "quarter color mismatch")

endmodule

`default_nettype wire
